[hw/rtl/lstc_pkg.sv]
`default_nettype none

package lstc_pkg;

    // Vector words are quarter-mm scaled by 2^30; the angle word is degrees scaled by 2^22.
    localparam int VEC_W       = 49;
    localparam int ANG_W       = 32;
    localparam int ATAN_TBL_LEN = 24;
    localparam int GAIN_W      = 30;
    localparam int PROD_W      = 46;

    localparam logic [14:0]       FULL_TURN_Q6    = 15'd23040;
    localparam logic [14:0]       QUARTER_TURN_Q6 = 15'd5760;
    localparam logic [GAIN_W-1:0] GAIN_Q30        = 30'd652032874;
    localparam logic [15:0]       COORD_LIMIT     = 16'd16384;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    typedef struct packed {
        logic [5:0]  quality;
        logic [14:0] angle_q6;
        logic [15:0] dist_qmm;
        t_quad       quad;
        logic [12:0] rem;
    } t_item;

    typedef struct packed {
        logic [5:0]  quality;
        logic [14:0] angle_q6;
        logic [15:0] dist_qmm;
        t_quad       quad;
    } t_meta;

    // atan(2^-i) in degrees * 2^22, rounded to nearest
    function automatic logic [27:0] atan_q22(input int unsigned idx);
        logic [27:0] val;
        unique case (idx)
            0:  val = 28'd188743680;
            1:  val = 28'd111421900;
            2:  val = 28'd58872272;
            3:  val = 28'd29884485;
            4:  val = 28'd15000234;
            5:  val = 28'd7507429;
            6:  val = 28'd3754631;
            7:  val = 28'd1877430;
            8:  val = 28'd938729;
            9:  val = 28'd469366;
            10: val = 28'd234683;
            11: val = 28'd117342;
            12: val = 28'd58671;
            13: val = 28'd29335;
            14: val = 28'd14668;
            15: val = 28'd7334;
            16: val = 28'd3667;
            17: val = 28'd1833;
            18: val = 28'd917;
            19: val = 28'd458;
            20: val = 28'd229;
            21: val = 28'd115;
            22: val = 28'd57;
            23: val = 28'd29;
            default: val = 28'd0;
        endcase
        return val;
    endfunction

    // mm * 2^32 -> whole mm, truncated toward zero, clamped to the coordinate limit
    function automatic logic signed [15:0] trunc_mm(input logic signed [VEC_W-1:0] v);
        logic [VEC_W-1:0]  mag;
        logic [VEC_W-33:0] whole;
        logic [15:0]       lim;
        mag   = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
        whole = mag[VEC_W-1:32];
        if (whole > (VEC_W-32)'(COORD_LIMIT)) begin
            lim = COORD_LIMIT;
        end else begin
            lim = whole[15:0];
        end
        return v[VEC_W-1] ? -signed'(lim) : signed'(lim);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/lstc_front.sv]
`default_nettype none

module lstc_front #(
    parameter int QUALITY_SHIFT = 2,
    parameter int ANGLE_SHIFT   = 1
) (
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_quality_byte,
    input  wire logic [15:0]   i_angle_word,
    input  wire logic [15:0]   i_distance_word,
    input  wire logic          i_full,
    output logic               o_push,
    output lstc_pkg::t_item    o_item
);
    import lstc_pkg::*;

    logic [7:0]  q_sh;
    logic [15:0] a_sh;
    logic [14:0] ang;
    logic [14:0] ang_red;

    assign q_sh = i_quality_byte >> QUALITY_SHIFT;
    assign a_sh = i_angle_word >> ANGLE_SHIFT;
    assign ang  = a_sh[14:0];

    assign ang_red = (ang >= FULL_TURN_Q6) ? 15'(ang - FULL_TURN_Q6) : ang;

    assign o_stall = i_full;
    // zero distance marks an invalid sample: taken and dropped
    assign o_push  = i_valid && !i_full && (i_distance_word != 16'd0);

    always_comb begin
        o_item.quality  = q_sh[5:0];
        o_item.angle_q6 = ang;
        o_item.dist_qmm = i_distance_word;
        priority if (ang_red >= 15'(3 * QUARTER_TURN_Q6)) begin
            o_item.quad = QUAD_270;
            o_item.rem  = 13'(ang_red - 15'(3 * QUARTER_TURN_Q6));
        end else if (ang_red >= 15'(2 * QUARTER_TURN_Q6)) begin
            o_item.quad = QUAD_180;
            o_item.rem  = 13'(ang_red - 15'(2 * QUARTER_TURN_Q6));
        end else if (ang_red >= QUARTER_TURN_Q6) begin
            o_item.quad = QUAD_90;
            o_item.rem  = 13'(ang_red - QUARTER_TURN_Q6);
        end else begin
            o_item.quad = QUAD_0;
            o_item.rem  = ang_red[12:0];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lstc_queue.sv]
`default_nettype none

module lstc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  lstc_pkg::t_item    i_item,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output lstc_pkg::t_item    o_item
);
    import lstc_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lstc_rotator.sv]
`default_nettype none

module lstc_rotator #(
    parameter int ROTATION_STEPS = 18
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  lstc_pkg::t_item           i_item,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [5:0]                o_quality,
    output logic [14:0]               o_angle_q6,
    output logic [15:0]               o_dist_qmm,
    output logic signed [15:0]        o_x_mm,
    output logic signed [15:0]        o_y_mm
);
    import lstc_pkg::*;

    localparam int N = ROTATION_STEPS;

    logic                    r_v    [N+1];
    t_meta                   r_meta [N+1];
    logic signed [VEC_W-1:0] r_x    [N+1];
    logic signed [VEC_W-1:0] r_y    [N+1];
    logic signed [ANG_W-1:0] r_z    [N+1];

    logic                    r_out_v;
    logic [5:0]              r_out_quality;
    logic [14:0]             r_out_angle;
    logic [15:0]             r_out_dist;
    logic signed [15:0]      r_out_x;
    logic signed [15:0]      r_out_y;

    logic                    en;
    logic [PROD_W-1:0]       prod;
    logic signed [VEC_W-1:0] sn;
    logic signed [VEC_W-1:0] cs;

    // whole pipe moves together unless the output register is full and held
    assign en    = !r_out_v || !i_stall;
    assign o_pop = en && i_q_valid;
    assign prod  = PROD_W'(i_item.dist_qmm) * PROD_W'(GAIN_Q30);

    // stage 0: scaled start vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]             <= signed'(VEC_W'(prod));
            r_y[0]             <= '0;
            r_z[0]             <= ANG_W'({i_item.rem, 16'b0});
            r_meta[0].quality  <= i_item.quality;
            r_meta[0].angle_q6 <= i_item.angle_q6;
            r_meta[0].dist_qmm <= i_item.dist_qmm;
            r_meta[0].quad     <= i_item.quad;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic signed [ANG_W-1:0] ATAN_K = ANG_W'(atan_q22(k));
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;

        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_meta[k+1] <= r_meta[k];
                if (!r_z[k][ANG_W-1]) begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - ATAN_K;
                end else begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + ATAN_K;
                end
            end
        end
    end

    // quadrant swap and sign
    always_comb begin
        unique case (r_meta[N].quad)
            QUAD_0: begin
                sn = r_y[N];
                cs = r_x[N];
            end
            QUAD_90: begin
                sn = r_x[N];
                cs = -r_y[N];
            end
            QUAD_180: begin
                sn = -r_y[N];
                cs = -r_x[N];
            end
            QUAD_270: begin
                sn = -r_x[N];
                cs = r_y[N];
            end
            default: begin
                sn = '0;
                cs = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_quality <= r_meta[N].quality;
            r_out_angle   <= r_meta[N].angle_q6;
            r_out_dist    <= r_meta[N].dist_qmm;
            r_out_x       <= trunc_mm(sn);
            r_out_y       <= trunc_mm(cs);
        end
    end

    assign o_valid    = r_out_v;
    assign o_quality  = r_out_quality;
    assign o_angle_q6 = r_out_angle;
    assign o_dist_qmm = r_out_dist;
    assign o_x_mm     = r_out_x;
    assign o_y_mm     = r_out_y;

endmodule

`default_nettype wire

[hw/rtl/lidar_sample_to_cartesian_top.sv]
`default_nettype none

// Scanner sample to Cartesian point. Each input item (quality byte, angle
// word, distance word) is unpacked and, unless the distance is zero, turned
// into x = sin(angle)*distance and y = cos(angle)*distance in whole mm,
// truncated toward zero and clamped to +/-16384, next to the unpacked quality,
// angle (deg*64) and distance (quarter mm). Zero-distance items are taken and
// dropped. One item per cycle is accepted while i_stall does not hold results
// back; an accepted item passes through the queue, the gain-multiply stage
// and each rotation stage of the CORDIC pipe before it lands in the output
// register. A 4-entry queue sits between the unpack front and the rotation
// pipe; o_stall rises only when that queue is full, which happens only after
// i_stall has held results back.
module lidar_sample_to_cartesian_top #(
    parameter int QUALITY_SHIFT  = 2,   // 0..7
    parameter int ANGLE_SHIFT    = 1,   // 0..7
    parameter int ROTATION_STEPS = 18   // 12..24, one pipe stage each
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // sample channel
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_quality_byte,
    input  wire logic [15:0]   i_angle_word,
    input  wire logic [15:0]   i_distance_word,
    // point channel
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [5:0]         o_quality,
    output logic [14:0]        o_angle_q6,
    output logic [15:0]        o_dist_qmm,
    output logic signed [15:0] o_x_mm,
    output logic signed [15:0] o_y_mm
);
    import lstc_pkg::*;

    t_item front_item;
    t_item q_item;
    logic  front_push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    // unpack, drop invalid samples, fold angle into quadrant + remainder
    lstc_front #(
        .QUALITY_SHIFT (QUALITY_SHIFT),
        .ANGLE_SHIFT   (ANGLE_SHIFT)
    ) u_front (
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_quality_byte  (i_quality_byte),
        .i_angle_word    (i_angle_word),
        .i_distance_word (i_distance_word),
        .i_full          (q_full),
        .o_push          (front_push),
        .o_item          (front_item)
    );

    // decouples the front from the stallable rotation pipe
    lstc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    // gain multiply, CORDIC rotation, quadrant map, truncation
    lstc_rotator #(
        .ROTATION_STEPS (ROTATION_STEPS)
    ) u_rotator (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_quality  (o_quality),
        .o_angle_q6 (o_angle_q6),
        .o_dist_qmm (o_dist_qmm),
        .o_x_mm     (o_x_mm),
        .o_y_mm     (o_y_mm)
    );

endmodule

`default_nettype wire
